>>> hdl/assert_macros.svh
// Assertion helpers included by the bounded_deque top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/bdq_pkg.sv
package bdq_pkg;

  // Ring buffer geometry.
  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Operation codes.
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [2:0] OP_PEEK_REAR  = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
  } rsp_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } dq_sts_t;

endpackage

>>> hdl/bdq_ctrl.sv
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  dq_sts_t sts,
  output dq_cmd_t cmd
);

  ctrl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands. An item is latched in idle and applied once the
  // output register can take its result.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/bdq_datapath.sv
module bdq_datapath
  import bdq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  req_t             req,
  input  dq_cmd_t          cmd,
  output dq_sts_t          sts,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   head, head_next;
  logic [CNT_W-1:0]   occ, occ_next;
  logic [CAP_W-1:0]   capacity;
  req_t               item;
  rsp_t               result;
  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  logic [CNT_W:0]     tail_sum;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W-1:0]   rear;
  logic [PTR_W-1:0]   head_dec;
  logic [PTR_W-1:0]   head_inc;
  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   depth_ext;
  logic [CMP_W-1:0]   limit;
  logic               full;
  logic               empty;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(DEPTH > 16 ? 16 : DEPTH);
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // Ring positions: slot after the rear, the rear, and the neighbors of head.
  always_comb begin
    tail_sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(occ);
    if (tail_sum >= (CNT_W + 1)'(DEPTH)) begin
      tail = PTR_W'(tail_sum - (CNT_W + 1)'(DEPTH));
    end else begin
      tail = PTR_W'(tail_sum);
    end
    rear     = (tail == '0) ? PTR_W'(DEPTH - 1) : tail - PTR_W'(1);
    head_dec = (head == '0) ? PTR_W'(DEPTH - 1) : head - PTR_W'(1);
    head_inc = (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
  end

  // Occupancy limit saturates at the ring depth.
  always_comb begin
    cap_ext   = CMP_W'(capacity);
    depth_ext = CMP_W'(DEPTH);
    limit     = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    full      = CMP_W'(occ) >= limit;
    empty     = occ == '0;
  end

  // Peek address is chosen from the incoming transaction so the registered
  // read is ready in the execute cycle.
  assign rd_addr = (req.opcode == OP_PEEK_FRONT) ? head : rear;

  // Item register and entry read.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item    <= req;
      rd_data <= mem[rd_addr];
    end
  end

  // Execute the latched item: pointer updates, entry write and result.
  always_comb begin
    head_next     = head;
    occ_next      = occ;
    wr_en         = 1'b0;
    wr_addr       = tail;
    result.data   = '0;
    result.status = ST_OK;
    case (item.opcode)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (full) begin
          result.status = ST_FULL;
        end else begin
          wr_en    = 1'b1;
          occ_next = occ + CNT_W'(1);
          if (item.opcode == OP_PUSH_FRONT) begin
            head_next = head_dec;
            wr_addr   = head_dec;
          end
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (empty) begin
          result.status = ST_EMPTY;
        end else begin
          occ_next = occ - CNT_W'(1);
          if (item.opcode == OP_POP_FRONT) begin
            head_next = head_inc;
          end
        end
      end
      OP_PEEK_FRONT, OP_PEEK_REAR: begin
        if (empty) begin
          result.status = ST_EMPTY;
          result.data   = -32'sd1;
        end else begin
          result.data = rd_data;
        end
      end
      default: begin
      end
    endcase
  end

  // Entry memory write.
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= item.value;
    end
  end

  // Ring pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      occ  <= occ_next;
    end
  end

  // Output register; holds its transaction while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp <= result;
    end
  end

  assign sts.out_busy = rsp_valid && rsp_stall;

endmodule

>>> hdl/bounded_deque.sv
// Bounded double-ended queue of signed 32-bit values held in a ring buffer of
// 16 entries. Every request transaction (push front/rear, pop front/rear,
// peek front/rear) gives exactly one response transaction with data and a
// status of ok, full or empty. One request is in work at a time: it is
// latched and its entry read from the memory in the accept cycle, and applied
// once the output register can take its result, so no new request is taken
// before the previous one has been applied. The registered read port of the
// entry memory lies ahead of the pointer update. A new request is accepted
// while the previous response still waits in the output register. The
// capacity register (reset 16, values above 16 act as 16) is written through
// cfg_we and cfg_data; the user must write it only while the block is idle,
// which the block itself does not enforce. No clearing pass is needed after
// reset.
`include "assert_macros.svh"

module bounded_deque
  import bdq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp
);

  dq_cmd_t cmd;
  dq_sts_t sts;

  // Sequencing of each transaction.
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Ring buffer, pointers and output register.
  bdq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // An accepted request blocks the next one in the following cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall, "request taken back to back")

  // A result is never written over one that is still stalled.
  `ASSERT_SAME(a_no_overwrite, clk, rst, cmd.exec, !(rsp_valid && rsp_stall), "response overwritten")

  // Full responses carry zero data; only an empty peek returns nonzero data with a non-ok status.
  `ASSERT_SAME(a_full_data_zero, clk, rst, rsp_valid && rsp.status == ST_FULL, rsp.data == 32'sd0, "full response carries data")

  // An execute always leaves a valid response behind.
  `ASSERT_NEXT(a_exec_gives_rsp, clk, rst, cmd.exec, rsp_valid, "execute without response")

endmodule

>>> tb/tb_top.sv
module tb_top
  import bdq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes that the block treats as no operation.
  localparam logic [2:0] OP_NOP_LO = 3'd6;
  localparam logic [2:0] OP_NOP_HI = 3'd7;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 150;
  localparam int MAX_REPORTS = 10;

  // Shadow deque that predicts every response and holds the ones still owed.
  class deque_scoreboard;
    logic [31:0]      ring [DEPTH];
    logic [PTR_W-1:0] head;
    logic [CNT_W-1:0] fill;
    logic [CAP_W-1:0] capacity;
    rsp_t             owed [$];
    int               failures;

    function new();
      head = '0;
      fill = '0;
      capacity = CAP_W'(16);
      failures = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] v);
      capacity = v;
    endfunction

    function void report_failure(string what);
      if (failures < MAX_REPORTS) begin
        $display("[%0t] ERROR: %s", $realtime, what);
      end
      failures++;
    endfunction

    // Apply one accepted request transaction to the shadow deque.
    function void note_request(req_t item);
      rsp_t outcome;
      int   limit;
      outcome.data = '0;
      outcome.status = ST_OK;
      limit = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
      case (item.opcode)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (int'(fill) >= limit) begin
            outcome.status = ST_FULL;
          end else begin
            if (item.opcode == OP_PUSH_FRONT) begin
              head = head - 1'b1;
              ring[head] = item.value;
            end else begin
              ring[head + PTR_W'(fill)] = item.value;
            end
            fill = fill + 1'b1;
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (fill == '0) begin
            outcome.status = ST_EMPTY;
          end else begin
            if (item.opcode == OP_POP_FRONT) begin
              head = head + 1'b1;
            end
            fill = fill - 1'b1;
          end
        end
        OP_PEEK_FRONT, OP_PEEK_REAR: begin
          if (fill == '0) begin
            outcome.status = ST_EMPTY;
            outcome.data = -32'sd1;
          end else if (item.opcode == OP_PEEK_FRONT) begin
            outcome.data = ring[head];
          end else begin
            outcome.data = ring[head + PTR_W'(fill - 1'b1)];
          end
        end
        default: begin
        end
      endcase
      owed.push_back(outcome);
    endfunction

    // Compare one response transaction with the oldest prediction.
    function void check_response(rsp_t got);
      rsp_t want;
      if (owed.size() == 0) begin
        report_failure($sformatf("unexpected response data=%0d status=%0d",
                                 got.data, got.status));
        return;
      end
      want = owed.pop_front();
      if (got.data !== want.data) begin
        report_failure($sformatf("data mismatch: expected %0d, got %0d",
                                 want.data, got.data));
      end
      if (got.status !== want.status) begin
        report_failure($sformatf("status mismatch: expected %0d, got %0d",
                                 want.status, got.status));
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_stall;
  rsp_t             rsp;

  deque_scoreboard  sb;
  bit               steady;
  int               cycles = 0;

  bounded_deque i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none during steady stretches.
  function automatic int pick_gap();
    int roll;
    if (steady) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 20);
  endfunction

  function automatic req_t make_req(logic [2:0] op, logic [31:0] v);
    req_t item;
    item.opcode = op;
    item.value = v;
    return item;
  endfunction

  // Random request biased toward growing or shrinking the deque.
  function automatic req_t random_req(bit filling);
    int          roll;
    logic [2:0]  op;
    logic [31:0] v;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 70)      op = ($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      else if (roll < 85) op = ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_REAR;
      else if (roll < 97) op = ($urandom_range(0, 1) == 0) ? OP_PEEK_FRONT : OP_PEEK_REAR;
      else                op = ($urandom_range(0, 1) == 0) ? OP_NOP_LO : OP_NOP_HI;
    end else begin
      if (roll < 15)      op = ($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      else if (roll < 70) op = ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_REAR;
      else if (roll < 95) op = ($urandom_range(0, 1) == 0) ? OP_PEEK_FRONT : OP_PEEK_REAR;
      else                op = ($urandom_range(0, 1) == 0) ? OP_NOP_LO : OP_NOP_HI;
    end
    case ($urandom_range(0, 19))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = 32'hFFFF_FFFF;
      3:       v = 32'h0000_0000;
      default: v = $urandom;
    endcase
    return make_req(op, v);
  endfunction

  // Present one request transaction and hold it until it is taken.
  task automatic send_request(req_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
  endtask

  // Stop sending and wait until every predicted response has come back. The
  // first edge lets the monitor note a request taken at the previous edge.
  task automatic settle_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    settle_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(v);
  endtask

  // Random traffic in bursts, each biased to fill or to drain the deque.
  task automatic run_random(int count);
    int  sent;
    int  burst;
    bit  filling;
    sent = 0;
    filling = 1'b1;
    while (sent < count) begin
      burst = $urandom_range(8, 50);
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_request(random_req(filling));
        sent++;
      end
      filling = ($urandom_range(0, 2) != 0) ? ~filling : filling;
    end
    steady = 1'b0;
  endtask

  // Response side stalls in random patterns, except during steady stretches.
  initial begin
    int run_len;
    int hold_len;
    rsp_stall = 1'b0;
    forever begin
      run_len = $urandom_range(1, 24);
      hold_len = pick_gap();
      repeat (run_len) @(posedge clk);
      if (hold_len > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Observe both channels and compare each response transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        sb.check_response(rsp);
      end
      if (req_valid && !req_stall) begin
        sb.note_request(req);
      end
    end
  end

  // Main sequence: directed corners, then random phases at several capacities.
  initial begin
    logic [CAP_W-1:0] caps [10];
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_valid = 1'b0;
    req = '0;
    steady = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Every empty-deque case, then both ends with extreme values.
    send_request(make_req(OP_PEEK_FRONT, 32'h1234_5678));
    send_request(make_req(OP_PEEK_REAR, 32'h0));
    send_request(make_req(OP_POP_FRONT, 32'h0));
    send_request(make_req(OP_POP_REAR, 32'hFFFF_FFFF));
    send_request(make_req(OP_NOP_LO, 32'hDEAD_BEEF));
    send_request(make_req(OP_NOP_HI, 32'h0));
    send_request(make_req(OP_PUSH_REAR, 32'h7FFF_FFFF));
    send_request(make_req(OP_PUSH_FRONT, 32'h8000_0000));
    send_request(make_req(OP_PUSH_REAR, 32'hFFFF_FFFF));
    send_request(make_req(OP_PUSH_FRONT, 32'h0000_0000));
    send_request(make_req(OP_PEEK_FRONT, 32'h0));
    send_request(make_req(OP_PEEK_REAR, 32'h0));
    // A rear pop must expose the element before the removed one.
    send_request(make_req(OP_POP_REAR, 32'h0));
    send_request(make_req(OP_PEEK_REAR, 32'h0));
    send_request(make_req(OP_POP_FRONT, 32'h0));
    send_request(make_req(OP_PEEK_FRONT, 32'h0));
    send_request(make_req(OP_PUSH_FRONT, 32'h5555_5555));
    send_request(make_req(OP_PUSH_REAR, 32'hAAAA_AAAA));
    send_request(make_req(OP_PEEK_FRONT, 32'h0));
    send_request(make_req(OP_PEEK_REAR, 32'h0));
    send_request(make_req(OP_NOP_LO, 32'h0));
    steady = 1'b0;

    // The first change lowers the capacity from 16 to 1.
    caps = '{CAP_W'(1), CAP_W'(0), CAP_W'(31), CAP_W'(17), CAP_W'(3),
             CAP_W'(16), CAP_W'(2), CAP_W'(8), CAP_W'(0), CAP_W'(15)};
    caps[8] = CAP_W'($urandom_range(0, 31));
    run_random(PHASE_ITEMS / 2);
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      run_random(PHASE_ITEMS);
    end

    settle_idle();
    repeat (10) @(posedge clk);
    if (sb.owed.size() != 0) begin
      sb.report_failure($sformatf("%0d responses never arrived", sb.owed.size()));
    end
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
